[hdl/stu_pkg.sv]
// Shared types, character codes, token and error codes, and the saturating
// helpers of the source tokenizer. No dependencies.
package stu_pkg;

  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 32;
  localparam int LEN_BITS      = 16;
  localparam int MAX_RES       = 3;
  localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH   = MAX_RES + 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int KW_COUNT      = 8;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OFFSET_BITS-1:0]   off_t;
  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic [RES_CNT_W-1:0]     rcnt_t;
  typedef logic [QCNT_W-1:0]        qcnt_t;

  localparam pos_t POS_MAX = '1;
  localparam off_t OFF_MAX = '1;
  localparam len_t LEN_MAX = '1;

  typedef enum logic [3:0] {
    M_IDLE, M_EQ, M_GT, M_LT, M_BANG, M_SLASH, M_COMMENT, M_STRING,
    M_INT, M_DOT, M_FRAC, M_IDENT, M_HALT
  } mode_t;

  typedef enum logic [4:0] {
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COMMA, TK_PLUS, TK_MINUS,
    TK_STAR, TK_SLASH, TK_ASSIGN, TK_EQ, TK_NE, TK_GT, TK_GE, TK_LT, TK_LE,
    TK_STRING, TK_NUMBER, TK_IDENT, TK_TRUE, TK_FALSE, TK_IF, TK_ELSE,
    TK_WHILE, TK_LOOP, TK_BREAK, TK_PRINT, TK_EOF
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_BANG, ERR_UNEXPECTED, ERR_UNTERMINATED
  } err_t;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Keyword spellings, padded with NUL to eight bytes
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // true
    '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},  // false
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},  // while
    '{8'h6C, 8'h6F, 8'h6F, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // loop
    '{8'h62, 8'h72, 8'h65, 8'h61, 8'h6B, 8'h00, 8'h00, 8'h00},  // break
    '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00}   // print
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5
  };

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [31:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_vec_t;

  typedef struct packed {
    rcnt_t    n;
    res_vec_t item;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic off_t off_inc(input off_t a);
    return (a == OFF_MAX) ? a : a + off_t'(1);
  endfunction

  function automatic pos_t pos_inc(input pos_t a);
    return (a == POS_MAX) ? a : a + pos_t'(1);
  endfunction

  function automatic len_t len_grow(input len_t a, input logic [1:0] n);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + (LEN_BITS+1)'(n);
    return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
  endfunction

  function automatic off_t off_add_len(input off_t a, input len_t b);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + (OFFSET_BITS+1)'(b);
    return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
  endfunction

  function automatic pos_t pos_add_len(input pos_t a, input len_t b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return (s > 33'(POS_MAX)) ? POS_MAX : s[POSITION_BITS-1:0];
  endfunction

  function automatic logic [31:0] off_out(input off_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [15:0] pos_out(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic res_t mk_res(input kind_t k, input err_t e, input off_t off,
                                  input len_t len, input pos_t line, input pos_t col);
    res_t r;
    r.kind = k;
    r.err  = e;
    r.off  = off_out(off);
    r.len  = len;
    r.line = pos_out(line);
    r.col  = pos_out(col);
    r.last = 1'b0;
    return r;
  endfunction

  // Append one result; drop anything beyond the result limit
  function automatic void add_res(inout res_vec_t rv, inout rcnt_t n, input res_t r);
    if (n != rcnt_t'(MAX_RES)) begin
      rv[n] = r;
      n = n + rcnt_t'(1);
    end
  endfunction

  // Drop keywords that no longer match after byte c at position len
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                    input len_t len, input logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    r = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len >= len_t'(KW_LEN[k])) begin
        r[k] = 1'b0;
      end else if (KW_TEXT[k][len[2:0]] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic kind_t ident_kind(input logic [KW_COUNT-1:0] cand, input len_t len);
    kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (cand[i] && (len_t'(KW_LEN[i]) == len)) begin
        k = kind_t'(5'(TK_TRUE) + 5'(i));
      end
    end
    return k;
  endfunction

endpackage

[hdl/stu_scanner.sv]
// Per-byte scanner: scan state registers and the single-pass step logic that
// produces up to three results per byte. Depends on stu_pkg.
module stu_scanner import stu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       eos,
  output push_t      push
);

  mode_t               mode_r,     mode_nxt;
  logic                quote_r,    quote_nxt;
  off_t                byte_off_r, byte_off_nxt;
  pos_t                line_r,     line_nxt;
  pos_t                col_r,      col_nxt;
  off_t                ts_off_r,   ts_off_nxt;
  pos_t                ts_line_r,  ts_line_nxt;
  pos_t                ts_col_r,   ts_col_nxt;
  len_t                len_r,      len_nxt;
  logic [KW_COUNT-1:0] cand_r,     cand_nxt;

  res_vec_t step_res;
  rcnt_t    step_n;
  logic     do_begin;
  logic     digit;
  logic     alpha;
  logic     is_eq;

  assign digit = is_digit(ch);
  assign alpha = is_alpha(ch);
  assign is_eq = (ch == CH_EQ);

  // Next state and the results of this byte
  always_comb begin : step
    mode_nxt     = mode_r;
    quote_nxt    = quote_r;
    byte_off_nxt = byte_off_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    ts_off_nxt   = ts_off_r;
    ts_line_nxt  = ts_line_r;
    ts_col_nxt   = ts_col_r;
    len_nxt      = len_r;
    cand_nxt     = cand_r;
    step_res     = '0;
    step_n       = '0;
    do_begin     = 1'b0;

    // Close or extend the token in progress
    unique case (mode_r)
      M_HALT: begin
      end
      M_EQ: begin
        if (is_eq) begin
          add_res(step_res, step_n,
                  mk_res(TK_EQ, ERR_NONE, ts_off_nxt, len_t'(2), ts_line_nxt, ts_col_nxt));
          mode_nxt = M_IDLE;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_ASSIGN, ERR_NONE, ts_off_nxt, len_t'(1), ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_GT: begin
        if (is_eq) begin
          add_res(step_res, step_n,
                  mk_res(TK_GE, ERR_NONE, ts_off_nxt, len_t'(2), ts_line_nxt, ts_col_nxt));
          mode_nxt = M_IDLE;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_GT, ERR_NONE, ts_off_nxt, len_t'(1), ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_LT: begin
        if (is_eq) begin
          add_res(step_res, step_n,
                  mk_res(TK_LE, ERR_NONE, ts_off_nxt, len_t'(2), ts_line_nxt, ts_col_nxt));
          mode_nxt = M_IDLE;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_LT, ERR_NONE, ts_off_nxt, len_t'(1), ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_BANG: begin
        if (is_eq) begin
          add_res(step_res, step_n,
                  mk_res(TK_NE, ERR_NONE, ts_off_nxt, len_t'(2), ts_line_nxt, ts_col_nxt));
          mode_nxt = M_IDLE;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_LPAREN, ERR_BANG, ts_off_nxt, '0, ts_line_nxt, ts_col_nxt));
          mode_nxt = M_HALT;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_SLASH, ERR_NONE, ts_off_nxt, len_t'(1), ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_COMMENT: begin
        do_begin = (ch == CH_LF);
      end
      M_STRING: begin
        if (ch == (quote_r ? CH_SQ : CH_DQ)) begin
          add_res(step_res, step_n,
                  mk_res(TK_STRING, ERR_NONE, ts_off_nxt, len_nxt, ts_line_nxt, ts_col_nxt));
          mode_nxt = M_IDLE;
        end else begin
          len_nxt = len_grow(len_nxt, 2'd1);
        end
      end
      M_INT: begin
        if (digit) begin
          len_nxt = len_grow(len_nxt, 2'd1);
        end else if (ch == CH_DOT) begin
          mode_nxt = M_DOT;
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_NUMBER, ERR_NONE, ts_off_nxt, len_nxt, ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_DOT: begin
        if (digit) begin
          len_nxt  = len_grow(len_nxt, 2'd2);
          mode_nxt = M_FRAC;
        end else begin
          // number, then an error at the dot
          add_res(step_res, step_n,
                  mk_res(TK_NUMBER, ERR_NONE, ts_off_nxt, len_nxt, ts_line_nxt, ts_col_nxt));
          ts_off_nxt = off_add_len(ts_off_nxt, len_nxt);
          ts_col_nxt = pos_add_len(ts_col_nxt, len_nxt);
          add_res(step_res, step_n,
                  mk_res(TK_LPAREN, ERR_UNEXPECTED, ts_off_nxt, '0, ts_line_nxt, ts_col_nxt));
          mode_nxt = M_HALT;
        end
      end
      M_FRAC: begin
        if (digit) begin
          len_nxt = len_grow(len_nxt, 2'd1);
        end else begin
          add_res(step_res, step_n,
                  mk_res(TK_NUMBER, ERR_NONE, ts_off_nxt, len_nxt, ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      M_IDENT: begin
        if (alpha || digit) begin
          cand_nxt = kw_filter(cand_nxt, len_nxt, ch);
          len_nxt  = len_grow(len_nxt, 2'd1);
        end else begin
          add_res(step_res, step_n,
                  mk_res(ident_kind(cand_nxt, len_nxt), ERR_NONE, ts_off_nxt, len_nxt,
                         ts_line_nxt, ts_col_nxt));
          do_begin = 1'b1;
        end
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    // Start a new token at this byte
    if (do_begin) begin
      ts_off_nxt  = byte_off_r;
      ts_line_nxt = line_r;
      ts_col_nxt  = col_r;
      len_nxt     = '0;
      mode_nxt    = M_IDLE;
      unique case (ch)
        CH_LPAREN: add_res(step_res, step_n,
                           mk_res(TK_LPAREN, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_RPAREN: add_res(step_res, step_n,
                           mk_res(TK_RPAREN, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_LBRACE: add_res(step_res, step_n,
                           mk_res(TK_LBRACE, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_RBRACE: add_res(step_res, step_n,
                           mk_res(TK_RBRACE, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_COMMA:  add_res(step_res, step_n,
                           mk_res(TK_COMMA, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_PLUS:   add_res(step_res, step_n,
                           mk_res(TK_PLUS, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_MINUS:  add_res(step_res, step_n,
                           mk_res(TK_MINUS, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_STAR:   add_res(step_res, step_n,
                           mk_res(TK_STAR, ERR_NONE, ts_off_nxt, len_t'(1),
                                  ts_line_nxt, ts_col_nxt));
        CH_SLASH:  mode_nxt = M_SLASH;
        CH_EQ:     mode_nxt = M_EQ;
        CH_BANG:   mode_nxt = M_BANG;
        CH_GT:     mode_nxt = M_GT;
        CH_LT:     mode_nxt = M_LT;
        CH_SP, CH_CR, CH_TAB, CH_LF: begin
        end
        CH_DQ, CH_SQ: begin
          quote_nxt  = (ch == CH_SQ);
          ts_off_nxt = off_inc(byte_off_r);
          mode_nxt   = M_STRING;
        end
        default: begin
          if (digit) begin
            len_nxt  = len_t'(1);
            mode_nxt = M_INT;
          end else if (alpha) begin
            cand_nxt = kw_filter('1, '0, ch);
            len_nxt  = len_t'(1);
            mode_nxt = M_IDENT;
          end else begin
            add_res(step_res, step_n,
                    mk_res(TK_LPAREN, ERR_UNEXPECTED, ts_off_nxt, '0,
                           ts_line_nxt, ts_col_nxt));
            mode_nxt = M_HALT;
          end
        end
      endcase
    end

    // Advance the position past this byte
    byte_off_nxt = off_inc(byte_off_r);
    if (ch == CH_LF) begin
      line_nxt = pos_inc(line_r);
      col_nxt  = pos_t'(1);
    end else begin
      col_nxt  = pos_inc(col_r);
    end

    // Flush the pending token, give end of file unless halted, and return to reset values
    if (eos) begin
      unique case (mode_nxt)
        M_EQ: add_res(step_res, step_n,
                      mk_res(TK_ASSIGN, ERR_NONE, ts_off_nxt, len_t'(1),
                             ts_line_nxt, ts_col_nxt));
        M_GT: add_res(step_res, step_n,
                      mk_res(TK_GT, ERR_NONE, ts_off_nxt, len_t'(1),
                             ts_line_nxt, ts_col_nxt));
        M_LT: add_res(step_res, step_n,
                      mk_res(TK_LT, ERR_NONE, ts_off_nxt, len_t'(1),
                             ts_line_nxt, ts_col_nxt));
        M_SLASH: add_res(step_res, step_n,
                         mk_res(TK_SLASH, ERR_NONE, ts_off_nxt, len_t'(1),
                                ts_line_nxt, ts_col_nxt));
        M_BANG: begin
          add_res(step_res, step_n,
                  mk_res(TK_LPAREN, ERR_BANG, ts_off_nxt, '0, ts_line_nxt, ts_col_nxt));
          mode_nxt = M_HALT;
        end
        M_STRING: begin
          add_res(step_res, step_n,
                  mk_res(TK_LPAREN, ERR_UNTERMINATED, ts_off_nxt, '0,
                         ts_line_nxt, ts_col_nxt));
          mode_nxt = M_HALT;
        end
        M_INT, M_FRAC: add_res(step_res, step_n,
                               mk_res(TK_NUMBER, ERR_NONE, ts_off_nxt, len_nxt,
                                      ts_line_nxt, ts_col_nxt));
        M_DOT: begin
          add_res(step_res, step_n,
                  mk_res(TK_NUMBER, ERR_NONE, ts_off_nxt, len_nxt, ts_line_nxt, ts_col_nxt));
          ts_off_nxt = off_add_len(ts_off_nxt, len_nxt);
          ts_col_nxt = pos_add_len(ts_col_nxt, len_nxt);
          add_res(step_res, step_n,
                  mk_res(TK_LPAREN, ERR_UNEXPECTED, ts_off_nxt, '0, ts_line_nxt, ts_col_nxt));
          mode_nxt = M_HALT;
        end
        M_IDENT: add_res(step_res, step_n,
                         mk_res(ident_kind(cand_nxt, len_nxt), ERR_NONE, ts_off_nxt,
                                len_nxt, ts_line_nxt, ts_col_nxt));
        default: begin
        end
      endcase
      if (mode_nxt != M_HALT) begin
        add_res(step_res, step_n,
                mk_res(TK_EOF, ERR_NONE, byte_off_nxt, '0, line_nxt, col_nxt));
      end
      mode_nxt     = M_IDLE;
      quote_nxt    = 1'b0;
      byte_off_nxt = '0;
      line_nxt     = pos_t'(1);
      col_nxt      = pos_t'(1);
      ts_off_nxt   = '0;
      ts_line_nxt  = pos_t'(1);
      ts_col_nxt   = pos_t'(1);
      len_nxt      = '0;
      cand_nxt     = '1;
    end
  end

  // Result bundle toward the queue: mark the final result of the byte
  always_comb begin : outputs
    push.n    = accept ? step_n : '0;
    push.item = step_res;
    for (int i = 0; i < MAX_RES; i++) begin
      push.item[i].last = (rcnt_t'(i + 1) == step_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      quote_r    <= 1'b0;
      byte_off_r <= '0;
      line_r     <= pos_t'(1);
      col_r      <= pos_t'(1);
      ts_off_r   <= '0;
      ts_line_r  <= pos_t'(1);
      ts_col_r   <= pos_t'(1);
      len_r      <= '0;
      cand_r     <= '1;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      quote_r    <= quote_nxt;
      byte_off_r <= byte_off_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      ts_off_r   <= ts_off_nxt;
      ts_line_r  <= ts_line_nxt;
      ts_col_r   <= ts_col_nxt;
      len_r      <= len_nxt;
      cand_r     <= cand_nxt;
    end
  end

endmodule

[hdl/stu_result_queue.sv]
// Result register and short queue: takes up to three results per cycle and
// presents them from the head slot, at most one per cycle. Depends on stu_pkg.
module stu_result_queue import stu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop_ready,
  output res_t  head,
  output logic  head_valid,
  output logic  room
);

  res_t  slot_r [QUEUE_DEPTH];
  res_t  slot_nxt [QUEUE_DEPTH];
  res_t  shifted [QUEUE_DEPTH];
  qcnt_t count_r, count_nxt;
  qcnt_t base;
  qcnt_t sel;
  logic  pop;

  assign head_valid = (count_r != '0);
  assign head       = slot_r[0];
  assign pop        = head_valid && pop_ready;
  // room for a full burst of results even if nothing drains
  assign room       = (count_r <= qcnt_t'(QUEUE_DEPTH - MAX_RES));

  always_comb begin
    base      = count_r - qcnt_t'(pop);
    count_nxt = base + qcnt_t'(push.n);
    sel       = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shifted[i] = (i < QUEUE_DEPTH - 1) ? slot_r[(i + 1) % QUEUE_DEPTH] : slot_r[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel = qcnt_t'(i) - base;
      if (qcnt_t'(i) < base) begin
        slot_nxt[i] = pop ? shifted[i] : slot_r[i];
      end else if (sel < qcnt_t'(push.n)) begin
        slot_nxt[i] = push.item[sel[RES_CNT_W-1:0]];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

[hdl/source_tokenizer_unit.sv]
// Top level of the source tokenizer: stream ports, byte scanner and result
// queue. Depends on stu_pkg, stu_scanner and stu_result_queue.
//
// Source bytes enter one word per cycle on the in_ stream while in_tready is
// high, with in_tlast on the final byte of a source; tokens leave on the out_
// stream, one word per token, with out_tlast on the last token caused by a
// given byte. A byte is scanned in the cycle it is accepted and its tokens
// (none, one, two or three) land in a four-entry result queue. With the
// consumer always ready, the block sustains one byte per cycle; a byte that
// yields two or three tokens makes in_tready drop while the queue drains,
// because the queue head issues one token per cycle. Each token word carries
// start offset, lexeme length (strings exclude the quotes), start line and
// start column; the lexeme text itself is not sent. Error words carry kind
// zero and a nonzero error code; after an error nothing more is sent until
// the end-of-source byte, which also returns the scanner to its reset state.
module source_tokenizer_unit import stu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Source byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_source
  // Token stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] start_offset, [47:32] lexeme_length,
                                  // [63:48] start_line, [79:64] start_column
  output logic [6:0]  out_tuser,  // [4:0] token_kind, [6:5] error_code
  output logic        out_tlast   // last_of_run
);

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  // Take a byte only when the queue can hold a full burst of its results
  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  stu_scanner u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_tdata),
    .eos    (in_tlast),
    .push   (push)
  );

  stu_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  // Pack the head token onto the output word
  assign out_tdata = {head.col, head.line, head.len, head.off};
  assign out_tuser = {head.err, head.kind};
  assign out_tlast = head.last;

endmodule
